/* hdl/steq_pkg.sv */
// ----------------------------------------------------------------------------
// steq_pkg
// shared types and codes for the sorted event queue
// ----------------------------------------------------------------------------
package steq_pkg;

	// request codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// one stored event
	typedef struct packed {
		logic [31:0] event_time;
		logic        event_kind;
		logic [3:0]  process_id;
		logic [15:0] track_number;
		logic        is_write;
	} entry_t;

	// per-cycle operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_op_t;

endpackage

/* hdl/steq_cell.sv */
// ----------------------------------------------------------------------------
// steq_cell
// one slot of the sorted queue: keeps, shifts or takes the new event
// ----------------------------------------------------------------------------
module steq_cell
	import steq_pkg::*;
(
	input  logic     clk,
	input  cell_op_t op,
	input  entry_t   new_ent,
	input  logic     occ,
	input  logic     left_gt,
	input  entry_t   left_ent,
	input  entry_t   right_ent,
	output entry_t   ent,
	output logic     gt
);

	entry_t ent_q;

	// this slot holds a later event than the one coming in, so it moves right
	assign gt  = occ && (ent_q.event_time > new_ent.event_time);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (op.pop) begin
			ent_q <= right_ent;
		end else if (op.ins && !(occ && !gt)) begin
			if (left_gt) begin
				ent_q <= left_ent;
			end else begin
				ent_q <= new_ent;
			end
		end
	end

endmodule

/* hdl/stable_timed_event_queue.sv */
// ----------------------------------------------------------------------------
// stable_timed_event_queue
// bounded event queue kept sorted by time, stable for equal times
// ----------------------------------------------------------------------------
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// request  | start, busy            | cmd, event_time, event_kind, process_id,
//          |                        | track_number, is_write
// result   | done (one-cycle pulse) | status, out_time, out_kind, out_process,
//          |                        | out_track, out_write, occupancy
//
// a request is taken on any edge with start high and busy low; busy stays low,
// so one request per cycle is sustained
// the result is registered and shows in the cycle after its request; each cell
// makes a single compare against the incoming time
// reset clears the fill count and the result strobe; slot contents are not
// cleared and only slots below the fill count are ever read
// the receiver cannot stall: done flags each result for one cycle only
//
module stable_timed_event_queue
	import steq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [31:0] event_time,
	input  logic        event_kind,
	input  logic [3:0]  process_id,
	input  logic [15:0] track_number,
	input  logic        is_write,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] out_time,
	output logic        out_kind,
	output logic [3:0]  out_process,
	output logic [15:0] out_track,
	output logic        out_write,
	output logic [4:0]  occupancy
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// fill count and result registers
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_n;
	logic          done_q;
	logic [1:0]    status_q;
	entry_t        res_q;
	logic [4:0]    occupancy_q;

	logic     accept;
	logic     full;
	logic     empty;
	cell_op_t op;
	entry_t   new_ent;
	entry_t   res_n;
	logic [1:0] status_n;
	logic [CW+4:0] count_wide;

	// chain wiring
	entry_t ent [QUEUE_DEPTH];
	logic   gt  [QUEUE_DEPTH];
	logic   occ [QUEUE_DEPTH];

	// the queue never holds off a request
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	assign new_ent.event_time   = event_time;
	assign new_ent.event_kind   = event_kind;
	assign new_ent.process_id   = process_id;
	assign new_ent.track_number = track_number;
	assign new_ent.is_write     = is_write;

	// operation seen by every cell this cycle; rejected requests leave slots alone
	always_comb begin
		op.ins = accept && (cmd == CMD_INSERT) && !full;
		op.pop = accept && (cmd == CMD_POP) && !empty;
	end

	// next fill count, result status and popped data
	always_comb begin
		count_n  = count_q;
		status_n = STATUS_OK;
		res_n    = '0;
		if (cmd == CMD_INSERT) begin
			if (full) begin
				status_n = STATUS_FULL;
			end else begin
				count_n = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_n = STATUS_EMPTY;
			end else begin
				count_n = count_q - 1'b1;
				res_n   = ent[0];
			end
		end
	end

	// occupancy port is five bits wide whatever the depth
	assign count_wide = (CW+5)'(count_n);

	// row of cells; each one sees its neighbors and the incoming event
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_gt;

		assign occ[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign left_gt  = 1'b0;
			assign left_ent = new_ent;
		end else begin : g_body
			assign left_gt  = gt[i-1];
			assign left_ent = ent[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			// last slot empties on a pop, its contents no longer matter
			assign right_ent = ent[i];
		end else begin : g_mid
			assign right_ent = ent[i+1];
		end

		steq_cell u_cell (
			.clk       (clk),
			.op        (op),
			.new_ent   (new_ent),
			.occ       (occ[i]),
			.left_gt   (left_gt),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.ent       (ent[i]),
			.gt        (gt[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_n;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_n;
			res_q       <= res_n;
			occupancy_q <= count_wide[4:0];
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_time    = res_q.event_time;
	assign out_kind    = res_q.event_kind;
	assign out_process = res_q.process_id;
	assign out_track   = res_q.track_number;
	assign out_write   = res_q.is_write;
	assign occupancy   = occupancy_q;

	// every request gets its result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without result");

	// fill count stays within the row of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("fill count beyond depth");

	// head two events are in time order
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (ent[0].event_time <= ent[1].event_time))
		else $error("queue head out of order");

	// full report only when the queue was at depth and stays there
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_FULL) |-> (count_q == CW'(QUEUE_DEPTH)))
		else $error("full status with room left");

endmodule

/* tb/sv/steq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// steq_checker
// watches the request and result channels of the sorted event queue, keeps
// its own sorted copy of the stored events and compares every result
// ----------------------------------------------------------------------------
module steq_checker
	import steq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        cmd,
	input  logic [31:0] event_time,
	input  logic        event_kind,
	input  logic [3:0]  process_id,
	input  logic [15:0] track_number,
	input  logic        is_write,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] out_time,
	input  logic        out_kind,
	input  logic [3:0]  out_process,
	input  logic [15:0] out_track,
	input  logic        out_write,
	input  logic [4:0]  occupancy,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned pops_served,
	output int unsigned empty_hits,
	output int unsigned full_hits
);

	typedef struct packed {
		logic [1:0] status;
		entry_t     ev;
		logic [4:0] occupancy;
	} queue_result_t;

	entry_t        model_events[$];
	queue_result_t awaited_results[$];

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// stable sorted insert or head removal on the model copy
	task automatic predict_queue_result();
		entry_t        incoming;
		queue_result_t res;
		int            pos;
		res = '0;
		incoming.event_time   = event_time;
		incoming.event_kind   = event_kind;
		incoming.process_id   = process_id;
		incoming.track_number = track_number;
		incoming.is_write     = is_write;
		if (cmd == CMD_INSERT) begin
			if (model_events.size() >= QUEUE_DEPTH) begin
				res.status = STATUS_FULL;
				full_hits++;
			end else begin
				pos = 0;
				while (pos < model_events.size() &&
						model_events[pos].event_time <= incoming.event_time)
					pos++;
				model_events.insert(pos, incoming);
				res.status = STATUS_OK;
			end
		end else begin
			if (model_events.size() == 0) begin
				res.status = STATUS_EMPTY;
				empty_hits++;
			end else begin
				res.ev     = model_events.pop_front();
				res.status = STATUS_OK;
				pops_served++;
			end
		end
		res.occupancy = 5'(model_events.size());
		awaited_results.push_back(res);
	endtask

	task automatic check_queue_result();
		queue_result_t want;
		bit            bad;
		if (awaited_results.size() == 0) begin
			note_failure($sformatf("%0t: result strobe with no request outstanding", $realtime));
			return;
		end
		want = awaited_results.pop_front();
		bad = (status !== want.status) ||
			(out_time !== want.ev.event_time) ||
			(out_kind !== want.ev.event_kind) ||
			(out_process !== want.ev.process_id) ||
			(out_track !== want.ev.track_number) ||
			(out_write !== want.ev.is_write) ||
			(occupancy !== want.occupancy);
		if (bad)
			note_failure($sformatf({"%0t: mismatch\n",
				"  expected status %0d time %h kind %0d proc %0d track %h write %0d occ %0d\n",
				"  got      status %0d time %h kind %0d proc %0d track %h write %0d occ %0d"},
				$realtime, want.status, want.ev.event_time, want.ev.event_kind,
				want.ev.process_id, want.ev.track_number, want.ev.is_write, want.occupancy,
				status, out_time, out_kind, out_process, out_track, out_write, occupancy));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_events.delete();
			awaited_results.delete();
			fail_count  = 0;
			pops_served = 0;
			empty_hits  = 0;
			full_hits   = 0;
		end else begin
			if (done === 1'b1)
				check_queue_result();
			else if (done !== 1'b0)
				note_failure($sformatf("%0t: result strobe unknown", $realtime));
			if (start && busy === 1'b0)
				predict_queue_result();
		end
		pending = awaited_results.size();
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives inserts and pops into the sorted event queue with random gaps; a
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
	import steq_pkg::*;

	localparam int QUEUE_DEPTH     = 16;
	localparam int RANDOM_REQUESTS = 850;
	// runaway limit, well above the worst case with drains included
	localparam int CYCLE_LIMIT     = 200000;

	// how event times are drawn within one random phase
	typedef enum logic [1:0] {
		TM_CLUSTER,	// a handful of values, lots of equal times
		TM_SPREAD,	// anywhere in the 32-bit range
		TM_EDGE		// hugging zero and the top of the range
	} time_mode_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [31:0] event_time;
	logic        event_kind;
	logic [3:0]  process_id;
	logic [15:0] track_number;
	logic        is_write;
	logic        done;
	logic [1:0]  status;
	logic [31:0] out_time;
	logic        out_kind;
	logic [3:0]  out_process;
	logic [15:0] out_track;
	logic        out_write;
	logic [4:0]  occupancy;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned pops_served;
	int unsigned empty_hits;
	int unsigned full_hits;
	int unsigned requests_sent;
	int unsigned cycle_count = 0;

	stable_timed_event_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (.*);

	steq_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// present one request at a falling edge and hold it until taken
	task automatic issue(input logic op, input logic [31:0] t, input logic kind,
			input logic [3:0] proc, input logic [15:0] trk, input logic wr);
		start        <= 1'b1;
		cmd          <= op;
		event_time   <= t;
		event_kind   <= kind;
		process_id   <= proc;
		track_number <= trk;
		is_write     <= wr;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic idle_for(input int unsigned n);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// hold off until every outstanding result has come back
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_time(input time_mode_t mode);
		case (mode)
			TM_CLUSTER: return $urandom_range(0, 7);
			TM_EDGE: begin
				if ($urandom_range(0, 1))
					return $urandom_range(0, 3);
				else
					return 32'hFFFF_FFFF - $urandom_range(0, 3);
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned random_sent;
		int unsigned phase_len;
		int unsigned insert_pct;
		time_mode_t  tmode;
		bit          steady;
		logic        op;

		// every input known from time zero
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_INSERT;
		event_time   = '0;
		event_kind   = 1'b0;
		process_id   = '0;
		track_number = '0;
		is_write     = 1'b0;
		requests_sent = 0;
		random_sent  = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// pop straight after reset finds nothing, junk payload must not leak out
		issue(CMD_POP, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'hFFFF, 1'b1);
		// equal times leave in arrival order
		issue(CMD_INSERT, 32'd100, 1'b0, 4'h0, 16'h0000, 1'b0);
		issue(CMD_INSERT, 32'd100, 1'b1, 4'hF, 16'hFFFF, 1'b1);
		// both ends of the time range
		issue(CMD_INSERT, 32'h0000_0000, 1'b0, 4'h1, 16'h0001, 1'b0);
		issue(CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 4'hE, 16'hFFFE, 1'b1);
		issue(CMD_INSERT, 32'd100, 1'b0, 4'h5, 16'h5A5A, 1'b1);
		// fill to the brim with more ties against what is already stored
		for (int i = 0; i < 11; i++)
			issue(CMD_INSERT, 32'((i % 4) * 50), i[0], 4'(i), 16'(i * 4097), ~i[0]);
		// insert into a full queue is dropped, would otherwise land behind the stored zero times
		issue(CMD_INSERT, 32'h0000_0000, 1'b1, 4'hF, 16'hFFFF, 1'b1);
		// pops ignore whatever sits on the payload inputs
		repeat (5)
			issue(CMD_POP, $urandom, 1'b1, 4'hF, 16'hFFFF, 1'b1);
		wait_drained();

		// --- random part ---
		// phases lean toward inserts or pops so both full and empty get hit,
		// with a time distribution chosen per phase
		while (random_sent < RANDOM_REQUESTS) begin
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 3))
				0:       insert_pct = 15;
				1:       insert_pct = 50;
				2:       insert_pct = 85;
				default: insert_pct = 97;
			endcase
			tmode  = time_mode_t'($urandom_range(0, 2));
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < phase_len && random_sent < RANDOM_REQUESTS; i++) begin
				if (!steady)
					idle_for(pick_gap());
				op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP;
				issue(op, pick_time(tmode), 1'($urandom_range(0, 1)),
					4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
				random_sent++;
			end
			// now and then let everything settle before the next phase
			if ($urandom_range(0, 4) == 0)
				wait_drained();
		end

		wait_drained();
		// each result comes back on the next cycle; leave a little slack for strays
		repeat (4) @(posedge clk);

		$display("summary: %0d requests; %0d pops returned an event", requests_sent,
			pops_served);
		$display("summary: %0d pops found the queue empty, %0d inserts found it full",
			empty_hits, full_hits);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

/* stable_timed_event_queue.f */
hdl/steq_pkg.sv
hdl/steq_cell.sv
hdl/stable_timed_event_queue.sv
tb/sv/steq_checker.sv
tb/sv/tb_top.sv
